FILE: rtl/sstok_pkg.sv
// ----------------------------------------------------------------------------
// sstok_pkg: shared types, constants and helpers of the shader tokenizer
// Token kinds, scanner modes, the result record and byte classifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package sstok_pkg;

	localparam int LINE_BITS   = 16;
	localparam int OFFSET_BITS = 24;
	localparam int LEN_BITS    = 16;
	localparam int KIND_BITS   = 6;
	localparam int KW_BITS     = 48;
	localparam int KW_CHARS    = KW_BITS / 8;

	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [LEN_BITS-1:0]    LEN_MAX    = '1;

	// result queue
	localparam int Q_DEPTH  = 4;
	localparam int QA_BITS  = $clog2(Q_DEPTH);
	localparam int CNT_BITS = QA_BITS + 1;

	typedef logic [KIND_BITS-1:0] kind_t;

	localparam kind_t K_EOF          = 6'd0;
	localparam kind_t K_INT          = 6'd1;
	localparam kind_t K_FLOAT        = 6'd2;
	localparam kind_t K_IDENT        = 6'd3;
	localparam kind_t KEY_VOID       = 6'd4;
	localparam kind_t KEY_FLOAT      = 6'd5;
	localparam kind_t KEY_INT        = 6'd6;
	localparam kind_t KEY_UINT       = 6'd7;
	localparam kind_t KEY_BOOL       = 6'd8;
	localparam kind_t KEY_DOUBLE     = 6'd9;
	localparam kind_t KEY_VEC2       = 6'd10;
	localparam kind_t KEY_VEC3       = 6'd11;
	localparam kind_t KEY_VEC4       = 6'd12;
	localparam kind_t KEY_IF         = 6'd13;
	localparam kind_t KEY_ELSE       = 6'd14;
	localparam kind_t KEY_FOR        = 6'd15;
	localparam kind_t KEY_WHILE      = 6'd16;
	localparam kind_t KEY_RETURN     = 6'd17;
	localparam kind_t KEY_LAYOUT     = 6'd18;
	localparam kind_t KEY_BUFFER     = 6'd19;
	localparam kind_t KEY_IN         = 6'd20;
	localparam kind_t KEY_OUT        = 6'd21;
	localparam kind_t KEY_TRUE       = 6'd22;
	localparam kind_t KEY_FALSE      = 6'd23;
	localparam kind_t KEY_STRUCT     = 6'd24;
	localparam kind_t KEY_BREAK      = 6'd25;
	localparam kind_t KEY_CONTINUE   = 6'd26;
	localparam kind_t KEY_CONST      = 6'd27;
	localparam kind_t K_SEMICOLON    = 6'd28;
	localparam kind_t K_OBRACE       = 6'd29;
	localparam kind_t K_CBRACE       = 6'd30;
	localparam kind_t K_OPAREN       = 6'd31;
	localparam kind_t K_CPAREN       = 6'd32;
	localparam kind_t K_OBRACKET     = 6'd33;
	localparam kind_t K_CBRACKET     = 6'd34;
	localparam kind_t K_COMMA        = 6'd35;
	localparam kind_t K_DOT          = 6'd36;
	localparam kind_t K_HASH         = 6'd37;
	localparam kind_t K_EQ           = 6'd38;
	localparam kind_t K_PLUS_EQ      = 6'd39;
	localparam kind_t K_MINUS_EQ     = 6'd40;
	localparam kind_t K_STAR_EQ      = 6'd41;
	localparam kind_t K_SLASH_EQ     = 6'd42;
	localparam kind_t K_PLUS         = 6'd43;
	localparam kind_t K_MINUS        = 6'd44;
	localparam kind_t K_STAR         = 6'd45;
	localparam kind_t K_SLASH        = 6'd46;
	localparam kind_t K_PLUS_PLUS    = 6'd47;
	localparam kind_t K_MINUS_MINUS  = 6'd48;
	localparam kind_t K_EQ_EQ        = 6'd49;
	localparam kind_t K_NOT_EQ       = 6'd50;
	localparam kind_t K_LESS         = 6'd51;
	localparam kind_t K_GREATER      = 6'd52;
	localparam kind_t K_LESS_EQ      = 6'd53;
	localparam kind_t K_GREATER_EQ   = 6'd54;
	localparam kind_t K_AND_AND      = 6'd55;
	localparam kind_t K_OR_OR        = 6'd56;
	localparam kind_t K_BANG         = 6'd57;
	localparam kind_t K_AMP          = 6'd58;
	localparam kind_t K_PIPE         = 6'd59;
	localparam kind_t K_CARET        = 6'd60;
	localparam kind_t K_TILDE        = 6'd61;
	localparam kind_t K_UNKNOWN      = 6'd62;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_NUM_INT,
		M_NUM_FRAC,
		M_OP,
		M_LINE_COMMENT,
		M_BLOCK,
		M_BLOCK_STAR
	} mode_t;

	typedef struct packed {
		kind_t                  kind;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   column;
		logic [OFFSET_BITS-1:0] offset;
		logic [LEN_BITS-1:0]    length;
		logic                   last;
	} token_t;

	// up to two tokens per source byte, a always first
	typedef struct packed {
		logic [1:0] n;
		token_t     a;
		token_t     b;
	} push_t;

	function automatic logic is_alpha(input logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return (l >= "a") && (l <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
	endfunction

	function automatic logic may_pair(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
			(c == "!") || (c == "<") || (c == ">") || (c == "&") || (c == "|");
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			"/":     k = K_SLASH;
			"=":     k = K_EQ;
			"!":     k = K_BANG;
			"<":     k = K_LESS;
			">":     k = K_GREATER;
			"&":     k = K_AMP;
			"|":     k = K_PIPE;
			"(":     k = K_OPAREN;
			")":     k = K_CPAREN;
			"{":     k = K_OBRACE;
			"}":     k = K_CBRACE;
			"[":     k = K_OBRACKET;
			"]":     k = K_CBRACKET;
			";":     k = K_SEMICOLON;
			",":     k = K_COMMA;
			".":     k = K_DOT;
			"#":     k = K_HASH;
			"^":     k = K_CARET;
			"~":     k = K_TILDE;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	// K_EOF when the pair is no operator
	function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
		kind_t k;
		k = K_EOF;
		if (b == "=") begin
			case (a)
				"+":     k = K_PLUS_EQ;
				"-":     k = K_MINUS_EQ;
				"*":     k = K_STAR_EQ;
				"/":     k = K_SLASH_EQ;
				"=":     k = K_EQ_EQ;
				"!":     k = K_NOT_EQ;
				"<":     k = K_LESS_EQ;
				">":     k = K_GREATER_EQ;
				default: k = K_EOF;
			endcase
		end else if (a == b) begin
			case (a)
				"+":     k = K_PLUS_PLUS;
				"-":     k = K_MINUS_MINUS;
				"&":     k = K_AND_AND;
				"|":     k = K_OR_OR;
				default: k = K_EOF;
			endcase
		end
		return k;
	endfunction

	// buf holds the first up-to-six bytes right aligned, upper bytes zero
	function automatic kind_t ident_kind(input logic [KW_BITS-1:0] buf_w,
			input logic [LEN_BITS-1:0] len);
		kind_t k;
		k = K_IDENT;
		if (len <= LEN_BITS'(KW_CHARS)) begin
			case (buf_w)
				KW_BITS'("void"):   k = KEY_VOID;
				KW_BITS'("float"):  k = KEY_FLOAT;
				KW_BITS'("int"):    k = KEY_INT;
				KW_BITS'("uint"):   k = KEY_UINT;
				KW_BITS'("bool"):   k = KEY_BOOL;
				KW_BITS'("double"): k = KEY_DOUBLE;
				KW_BITS'("vec2"):   k = KEY_VEC2;
				KW_BITS'("vec3"):   k = KEY_VEC3;
				KW_BITS'("vec4"):   k = KEY_VEC4;
				KW_BITS'("if"):     k = KEY_IF;
				KW_BITS'("else"):   k = KEY_ELSE;
				KW_BITS'("for"):    k = KEY_FOR;
				KW_BITS'("while"):  k = KEY_WHILE;
				KW_BITS'("return"): k = KEY_RETURN;
				KW_BITS'("layout"): k = KEY_LAYOUT;
				KW_BITS'("buffer"): k = KEY_BUFFER;
				KW_BITS'("in"):     k = KEY_IN;
				KW_BITS'("out"):    k = KEY_OUT;
				KW_BITS'("true"):   k = KEY_TRUE;
				KW_BITS'("false"):  k = KEY_FALSE;
				KW_BITS'("struct"): k = KEY_STRUCT;
				KW_BITS'("break"):  k = KEY_BREAK;
				KW_BITS'("const"):  k = KEY_CONST;
				default:            k = K_IDENT;
			endcase
		end
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sstok_lexer.sv
// ----------------------------------------------------------------------------
// sstok_lexer: scanner state and per-byte token decision
// Updates the scan state for one byte and gives zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module sstok_lexer
	import sstok_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] ch,
	input  wire logic       eos,
	output push_t           push
);

	mode_t                  mode_q, mode_n;
	logic [7:0]             pend_q, pend_n;
	logic [KW_BITS-1:0]     kw_q, kw_n;
	logic                   float_q, float_n;
	logic [LINE_BITS-1:0]   line_q, line_n, col_q, col_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [LINE_BITS-1:0]   sline_q, sline_n, scol_q, scol_n;
	logic [OFFSET_BITS-1:0] soff_q, soff_n;
	logic [LEN_BITS-1:0]    len_q, len_n;

	logic [LINE_BITS-1:0]   adv_line, adv_col;
	logic [OFFSET_BITS-1:0] adv_off;
	logic [LEN_BITS-1:0]    len_inc;
	logic [KW_BITS-1:0]     kw_take;
	logic                   fl_v, sc_v, handled;
	token_t                 fl, sc;
	kind_t                  pk;

	// position after this byte
	always_comb begin
		adv_off = (off_q == OFFSET_MAX) ? off_q : off_q + OFFSET_BITS'(1);
		if (ch == 8'h0a) begin
			adv_line = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);
			adv_col  = LINE_BITS'(1);
		end else begin
			adv_line = line_q;
			adv_col  = (col_q == LINE_MAX) ? col_q : col_q + LINE_BITS'(1);
		end
		len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_BITS'(1);
		kw_take = (len_q < LEN_BITS'(KW_CHARS)) ? {kw_q[KW_BITS-9:0], ch} : kw_q;
		pk      = pair_kind(pend_q, ch);
	end

	// token pending in the current mode
	always_comb begin
		fl        = '0;
		fl.line   = sline_q;
		fl.column = scol_q;
		fl.offset = soff_q;
		case (mode_q)
			M_IDENT: begin
				fl.kind   = ident_kind(kw_q, len_q);
				fl.length = len_q;
			end
			M_NUM_INT, M_NUM_FRAC: begin
				fl.kind   = float_q ? K_FLOAT : K_INT;
				fl.length = len_q;
			end
			M_OP: begin
				fl.kind = single_kind(pend_q);
			end
			default: begin
				fl.kind = K_EOF;
			end
		endcase
	end

	always_comb begin
		mode_n  = mode_q;
		pend_n  = pend_q;
		kw_n    = kw_q;
		float_n = float_q;
		line_n  = line_q;
		col_n   = col_q;
		off_n   = off_q;
		sline_n = sline_q;
		scol_n  = scol_q;
		soff_n  = soff_q;
		len_n   = len_q;
		fl_v    = 1'b0;
		sc_v    = 1'b0;
		handled = 1'b0;
		sc        = '0;
		sc.line   = sline_q;
		sc.column = scol_q;
		sc.offset = soff_q;
		sc.kind   = K_EOF;

		if (eos) begin
			fl_v = (mode_q == M_IDENT) || (mode_q == M_NUM_INT) ||
				(mode_q == M_NUM_FRAC) || (mode_q == M_OP);
			sc_v      = 1'b1;
			sc.line   = line_q;
			sc.column = col_q;
			sc.offset = off_q;
			sc.last   = 1'b1;
			mode_n  = M_IDLE;
			pend_n  = '0;
			kw_n    = '0;
			float_n = 1'b0;
			line_n  = LINE_BITS'(1);
			col_n   = LINE_BITS'(1);
			off_n   = '0;
			sline_n = '0;
			scol_n  = '0;
			soff_n  = '0;
			len_n   = '0;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_word(ch)) begin
						handled = 1'b1;
						kw_n = kw_take;
						len_n = len_inc;
					end
				end
				M_NUM_INT, M_NUM_FRAC: begin
					if (is_digit(ch)) begin
						handled = 1'b1;
						kw_n = kw_take;
						len_n = len_inc;
					end else if (ch == "." && mode_q == M_NUM_INT) begin
						handled = 1'b1;
						float_n = 1'b1;
						mode_n = M_NUM_FRAC;
						kw_n = kw_take;
						len_n = len_inc;
					end else if (ch == "f" || ch == "F") begin
						// suffix closes the float at once
						handled = 1'b1;
						kw_n = kw_take;
						len_n = len_inc;
						sc_v = 1'b1;
						sc.kind = K_FLOAT;
						sc.length = len_inc;
						mode_n = M_IDLE;
					end
				end
				M_OP: begin
					if (pend_q == "/" && (ch == "/" || ch == "*")) begin
						handled = 1'b1;
						mode_n = (ch == "/") ? M_LINE_COMMENT : M_BLOCK;
						pend_n = '0;
					end else if (pk != K_EOF) begin
						handled = 1'b1;
						sc_v = 1'b1;
						sc.kind = pk;
						mode_n = M_IDLE;
						pend_n = '0;
					end
				end
				M_LINE_COMMENT: begin
					handled = 1'b1;
					if (ch == 8'h0a) begin
						mode_n = M_IDLE;
					end
				end
				M_BLOCK: begin
					handled = 1'b1;
					if (ch == "*") begin
						mode_n = M_BLOCK_STAR;
					end
				end
				M_BLOCK_STAR: begin
					handled = 1'b1;
					if (ch == "/") begin
						mode_n = M_IDLE;
					end else if (ch != "*") begin
						mode_n = M_BLOCK;
					end
				end
				default: begin
					handled = 1'b0;
				end
			endcase

			if (!handled) begin
				// pending token ends here, byte starts afresh
				fl_v = (mode_q == M_IDENT) || (mode_q == M_NUM_INT) ||
					(mode_q == M_NUM_FRAC) || (mode_q == M_OP);
				mode_n  = M_IDLE;
				pend_n  = '0;
				float_n = 1'b0;
				if (!is_space(ch)) begin
					sline_n = line_q;
					scol_n  = col_q;
					soff_n  = off_q;
					len_n   = '0;
					kw_n    = '0;
					if (is_alpha(ch) || ch == "_" || is_digit(ch)) begin
						mode_n = is_digit(ch) ? M_NUM_INT : M_IDENT;
						kw_n   = KW_BITS'(ch);
						len_n  = LEN_BITS'(1);
					end else if (may_pair(ch)) begin
						mode_n = M_OP;
						pend_n = ch;
					end else begin
						sc_v      = 1'b1;
						sc.kind   = single_kind(ch);
						sc.line   = line_q;
						sc.column = col_q;
						sc.offset = off_q;
					end
				end
			end
			line_n = adv_line;
			col_n  = adv_col;
			off_n  = adv_off;
		end
	end

	always_comb begin
		push.n = {fl_v & sc_v, fl_v ^ sc_v};
		push.a = fl_v ? fl : sc;
		push.b = sc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= '0;
			kw_q    <= '0;
			float_q <= 1'b0;
			line_q  <= LINE_BITS'(1);
			col_q   <= LINE_BITS'(1);
			off_q   <= '0;
			sline_q <= '0;
			scol_q  <= '0;
			soff_q  <= '0;
			len_q   <= '0;
		end else if (go) begin
			mode_q  <= mode_n;
			pend_q  <= pend_n;
			kw_q    <= kw_n;
			float_q <= float_n;
			line_q  <= line_n;
			col_q   <= col_n;
			off_q   <= off_n;
			sline_q <= sline_n;
			scol_q  <= scol_n;
			soff_q  <= soff_n;
			len_q   <= len_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sstok_outq.sv
// ----------------------------------------------------------------------------
// sstok_outq: result queue
// Takes up to two tokens a cycle, hands out one a cycle in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sstok_outq
	import sstok_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire push_t               push,
	input  wire logic                pop,
	output token_t                   head,
	output logic     [CNT_BITS-1:0]  count
);

	token_t              mem_q [Q_DEPTH];
	logic [QA_BITS-1:0]  wp_q, rp_q;
	logic [CNT_BITS-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + QA_BITS'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QA_BITS'(push.n);
			rp_q  <= rp_q + QA_BITS'(pop);
			cnt_q <= cnt_q + CNT_BITS'(push.n) - CNT_BITS'(pop);
		end
	end

	assign head  = mem_q[rp_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

FILE: rtl/shader_source_tokenizer.sv
// ----------------------------------------------------------------------------
// shader_source_tokenizer: byte-serial lexer for C-like shader source
// Input register, scan step, four-entry result queue.
// ----------------------------------------------------------------------------
// Feed the source one byte per request on the slave side; a request with
// s_tlast set marks end of source (its data byte is ignored), flushes any
// token still open, gives an end-of-source token (kind K_EOF) with m_tlast set
// and returns the block to its reset state, so the next byte starts a fresh
// source. A request lands in the input register; once the queue has room, the
// scan step updates the mode, position and keyword registers and writes 0, 1
// or 2 tokens into the result queue, so a new byte is taken every cycle while
// the queue has room. The queue drains one token a cycle while m_tready is
// high; the input side stalls only while the queue could not take two more
// tokens (room check on the queue count), which happens when bytes that close
// two tokens at once come back to back or the master side holds m_tready low.
// A token passes through the input register and the scan step into the result
// queue before it is valid on m_*.
// Whitespace and comments give no token; identifiers and numbers are given
// when the byte after them arrives, an f/F suffix closes a float on the spot.
// Line, column, offset and length counters saturate rather than wrap.
`default_nettype none

module shader_source_tokenizer
	import sstok_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic        s_tlast,   // end_of_source
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [15:0] start_line, [31:16] start_column,
	                                    // [55:32] start_offset, [71:56] text_length
	output logic [7:0]       m_tuser,   // [5:0] kind, [7:6] zero
	output logic             m_tlast    // last
);

	logic                v_s1;
	logic [7:0]          ch_s1;
	logic                eos_s1;
	logic                go;
	logic                pop;
	push_t               push;
	token_t              head;
	logic [CNT_BITS-1:0] count;

	// scan step runs when the queue has room for two tokens
	assign go       = v_s1 && (count <= CNT_BITS'(Q_DEPTH - 2));
	assign s_tready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eos_s1 <= s_tlast;
		end
	end

	sstok_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.ch     (ch_s1),
		.eos    (eos_s1),
		.push   (push)
	);

	sstok_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go ? push : push_t'('0)),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign m_tvalid = (count != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {head.length, head.offset, head.column, head.line};
	assign m_tuser  = {2'b00, head.kind};
	assign m_tlast  = head.last;

endmodule

`default_nettype wire

FILE: rtl/sstok_chk.sv
// ----------------------------------------------------------------------------
// sstok_chk: port-level checks for the shader tokenizer
// Watches the master side and the input ready; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sstok_chk
	import sstok_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata,
	input wire logic [7:0]  m_tuser,
	input wire logic        m_tlast
);

	// stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled token changed");

	// tlast exactly on the end token
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[5:0] == K_EOF)))
		else $error("tlast does not match the end token");

	// continue is never reported as a keyword, kinds stay in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[5:0] != KEY_CONTINUE) && (m_tuser[5:0] <= K_UNKNOWN)
			&& (m_tuser[7:6] == 2'b00))
		else $error("bad token kind");

	// only identifiers, keywords and numbers carry a length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser[5:0] >= K_SEMICOLON) || (m_tuser[5:0] == K_EOF))
			|-> (m_tdata[71:56] == '0))
		else $error("length on a punctuation or end token");

	// with no token waiting the input side is always open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty queue");

endmodule

bind shader_source_tokenizer sstok_chk u_sstok_chk (.*);

`default_nettype wire

FILE: test/shader_source_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// shader_source_tokenizer_tb: self-checking bench for the shader tokenizer
// Feeds source bytes and end marks, predicts every token and compares the
// tokens coming out field by field. Random gaps fall on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module shader_source_tokenizer_tb;
	import sstok_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          RANDOM_BYTES = 1560;

	// bytes with a role of their own
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	shader_source_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Bookkeeping
	// ------------------------------------------------------------------------
	token_t      tokens_due[$];   // predicted tokens, oldest first
	int          mismatches;
	int          tokens_checked;
	int          bytes_fed;
	int          sources_ended;
	int unsigned cycle_count;
	bit          idle_en;         // random gaps on both sides when set
	int          hold_left;       // long receiver hold-off, counted below

	string kw_words [23] = '{"void", "float", "int", "uint", "bool", "double", "vec2",
		"vec3", "vec4", "if", "else", "for", "while", "return", "layout", "buffer",
		"in", "out", "true", "false", "struct", "break", "const"};
	kind_t kw_kinds [23] = '{KEY_VOID, KEY_FLOAT, KEY_INT, KEY_UINT, KEY_BOOL,
		KEY_DOUBLE, KEY_VEC2, KEY_VEC3, KEY_VEC4, KEY_IF, KEY_ELSE, KEY_FOR, KEY_WHILE,
		KEY_RETURN, KEY_LAYOUT, KEY_BUFFER, KEY_IN, KEY_OUT, KEY_TRUE, KEY_FALSE,
		KEY_STRUCT, KEY_BREAK, KEY_CONST};
	string op_words [34] = '{"+", "-", "*", "/", "=", "!", "<", ">", "&", "|",
		"+=", "-=", "*=", "/=", "==", "!=", "<=", ">=", "++", "--", "&&", "||",
		"(", ")", "{", "}", "[", "]", ";", ",", ".", "#", "^", "~"};

	// ------------------------------------------------------------------------
	// Lexer prediction: own copy of the scan state
	// ------------------------------------------------------------------------
	mode_t                  lex_mode;
	logic [7:0]             held_op;     // first byte of a possible pair
	logic [KW_BITS-1:0]     word_bytes;  // first six bytes of the word, right aligned
	logic                   frac_seen;
	logic [LINE_BITS-1:0]   pos_line, pos_col, tok_line, tok_col;
	logic [OFFSET_BITS-1:0] pos_ofs, tok_ofs;
	logic [LEN_BITS-1:0]    tok_len;

	function automatic void lex_reset();
		lex_mode   = M_IDLE;
		held_op    = '0;
		word_bytes = '0;
		frac_seen  = 1'b0;
		pos_line   = 1;
		pos_col    = 1;
		pos_ofs    = '0;
		tok_line   = '0;
		tok_col    = '0;
		tok_ofs    = '0;
		tok_len    = '0;
	endfunction

	function automatic bit letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return letter(c) || numeral(c) || c == "_";
	endfunction

	function automatic bit blank(input logic [7:0] c);
		return c == " " || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit op_lead(input logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "=", "!", "<", ">", "&", "|": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic kind_t lone_kind(input logic [7:0] c);
		case (c)
			";": return K_SEMICOLON;
			"{": return K_OBRACE;
			"}": return K_CBRACE;
			"(": return K_OPAREN;
			")": return K_CPAREN;
			"[": return K_OBRACKET;
			"]": return K_CBRACKET;
			",": return K_COMMA;
			".": return K_DOT;
			"#": return K_HASH;
			"=": return K_EQ;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"<": return K_LESS;
			">": return K_GREATER;
			"!": return K_BANG;
			"&": return K_AMP;
			"|": return K_PIPE;
			"^": return K_CARET;
			"~": return K_TILDE;
			default: return K_UNKNOWN;
		endcase
	endfunction

	// K_EOF means the two bytes do not form an operator
	function automatic kind_t duo_kind(input logic [7:0] a, input logic [7:0] b);
		case ({a, b})
			"+=": return K_PLUS_EQ;
			"-=": return K_MINUS_EQ;
			"*=": return K_STAR_EQ;
			"/=": return K_SLASH_EQ;
			"==": return K_EQ_EQ;
			"!=": return K_NOT_EQ;
			"<=": return K_LESS_EQ;
			">=": return K_GREATER_EQ;
			"++": return K_PLUS_PLUS;
			"--": return K_MINUS_MINUS;
			"&&": return K_AND_AND;
			"||": return K_OR_OR;
			default: return K_EOF;
		endcase
	endfunction

	// keyword lookup on the buffered bytes; "continue" is not in the list
	function automatic kind_t word_kind();
		kind_t k;
		int    n;
		bit    same;
		k = K_IDENT;
		n = int'(tok_len);
		if (n <= KW_CHARS) begin
			for (int w = 0; w < 23; w++) begin
				if (kw_words[w].len() == n) begin
					same = 1'b1;
					for (int i = 0; i < n; i++)
						if (word_bytes[8*(n-1-i) +: 8] != kw_words[w][i]) same = 1'b0;
					if (same) k = kw_kinds[w];
				end
			end
		end
		return k;
	endfunction

	// position moves on every byte; counters stop at all ones
	function automatic void advance_pos(input logic [7:0] c);
		if (pos_ofs != OFFSET_MAX) pos_ofs++;
		if (c == CH_LF) begin
			if (pos_line != LINE_MAX) pos_line++;
			pos_col = 1;
		end else if (pos_col != LINE_MAX) begin
			pos_col++;
		end
	endfunction

	function automatic void start_token();
		tok_line   = pos_line;
		tok_col    = pos_col;
		tok_ofs    = pos_ofs;
		tok_len    = '0;
		word_bytes = '0;
	endfunction

	function automatic void take_byte(input logic [7:0] c);
		if (tok_len < KW_CHARS) word_bytes = {word_bytes[KW_BITS-9:0], c};
		if (tok_len != LEN_MAX) tok_len++;
		advance_pos(c);
	endfunction

	function automatic void emit(input kind_t k, input logic [LEN_BITS-1:0] len,
			input logic is_last);
		token_t t;
		t.kind   = k;
		t.line   = tok_line;
		t.column = tok_col;
		t.offset = tok_ofs;
		t.length = len;
		t.last   = is_last;
		tokens_due.push_back(t);
	endfunction

	// close whatever token is open when its end becomes known
	function automatic void close_open_token();
		case (lex_mode)
			M_IDENT:              emit(word_kind(), tok_len, 1'b0);
			M_NUM_INT, M_NUM_FRAC: emit(frac_seen ? K_FLOAT : K_INT, tok_len, 1'b0);
			M_OP:                 emit(lone_kind(held_op), '0, 1'b0);
			default: ;
		endcase
	endfunction

	// one accepted request: works out the 0..2 tokens it gives
	function automatic void lex_byte(input logic [7:0] c, input logic eos);
		kind_t pk;
		if (eos) begin
			close_open_token();
			tok_line = pos_line;
			tok_col  = pos_col;
			tok_ofs  = pos_ofs;
			emit(K_EOF, '0, 1'b1);
			lex_reset();
			return;
		end
		case (lex_mode)
			M_IDENT: begin
				if (word_char(c)) begin
					take_byte(c);
					return;
				end
			end
			M_NUM_INT, M_NUM_FRAC: begin
				if (numeral(c)) begin
					take_byte(c);
					return;
				end
				if (c == "." && lex_mode == M_NUM_INT) begin
					frac_seen = 1'b1;
					lex_mode  = M_NUM_FRAC;
					take_byte(c);
					return;
				end
				// suffix closes the float on the spot
				if (c == "f" || c == "F") begin
					take_byte(c);
					emit(K_FLOAT, tok_len, 1'b0);
					lex_mode = M_IDLE;
					return;
				end
			end
			M_OP: begin
				if (held_op == "/" && (c == "/" || c == "*")) begin
					lex_mode = (c == "/") ? M_LINE_COMMENT : M_BLOCK;
					held_op  = '0;
					advance_pos(c);
					return;
				end
				pk = duo_kind(held_op, c);
				if (pk != K_EOF) begin
					emit(pk, '0, 1'b0);
					lex_mode = M_IDLE;
					held_op  = '0;
					advance_pos(c);
					return;
				end
			end
			M_LINE_COMMENT: begin
				if (c == CH_LF) lex_mode = M_IDLE;
				advance_pos(c);
				return;
			end
			M_BLOCK: begin
				if (c == "*") lex_mode = M_BLOCK_STAR;
				advance_pos(c);
				return;
			end
			M_BLOCK_STAR: begin
				if (c == "/") lex_mode = M_IDLE;
				else if (c != "*") lex_mode = M_BLOCK;
				advance_pos(c);
				return;
			end
			default: ;
		endcase
		// the open token ends here, c starts afresh
		close_open_token();
		lex_mode  = M_IDLE;
		held_op   = '0;
		frac_seen = 1'b0;
		if (blank(c)) begin
			advance_pos(c);
			return;
		end
		start_token();
		if (letter(c) || c == "_") begin
			lex_mode = M_IDENT;
			take_byte(c);
		end else if (numeral(c)) begin
			lex_mode = M_NUM_INT;
			take_byte(c);
		end else if (op_lead(c)) begin
			lex_mode = M_OP;
			held_op  = c;
			advance_pos(c);
		end else begin
			emit(lone_kind(c), '0, 1'b0);
			advance_pos(c);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Gaps: mostly none or short, now and then long
	// ------------------------------------------------------------------------
	function automatic int idle_len();
		int r;
		if (!idle_en) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one request per call, predicted when the handshake completes
	// ------------------------------------------------------------------------
	task automatic feed_byte(input logic [7:0] c, input logic eos);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		lex_byte(c, eos);
		bytes_fed++;
		if (eos) sources_ended++;
	endtask

	task automatic feed_text(input string s);
		for (int i = 0; i < s.len(); i++) feed_byte(s[i], 1'b0);
	endtask

	// end mark carries a random byte that must be ignored
	task automatic end_source();
		feed_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] any_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return "_";
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random stalls plus an explicit long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 7) == 0) stall_left = idle_len();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: each token against the oldest prediction
	// ------------------------------------------------------------------------
	function automatic void flag_mismatch(input string what, input longint unsigned want_v,
			input longint unsigned got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("token %0d: %s expected %0d, got %0d", tokens_checked, what, want_v,
				got_v);
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (tokens_due.size() == 0) begin
				flag_mismatch("unexpected token, kind", 0, m_tuser);
			end else begin
				want = tokens_due.pop_front();
				if (m_tuser != {2'b00, want.kind}) flag_mismatch("kind", want.kind, m_tuser);
				if (m_tdata[15:0] != want.line) flag_mismatch("line", want.line, m_tdata[15:0]);
				if (m_tdata[31:16] != want.column)
					flag_mismatch("column", want.column, m_tdata[31:16]);
				if (m_tdata[55:32] != want.offset)
					flag_mismatch("offset", want.offset, m_tdata[55:32]);
				if (m_tdata[71:56] != want.length)
					flag_mismatch("length", want.length, m_tdata[71:56]);
				if (m_tlast != want.last) flag_mismatch("last", want.last, m_tlast);
			end
			tokens_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still due", cycle_count,
				tokens_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// empty source; "continue" stays a word; "1." and "2f" are floats;
	// slash-star-slash does not close a comment; trailing lone slash
	task automatic test_special_cases();
		end_source();
		feed_text("continue 1. 2f/*/x*/a/");
		end_source();
	endtask

	// high and zero bytes are unknown; comments left open at the end just stop
	task automatic test_odd_bytes();
		feed_byte(8'hff, 1'b0);
		feed_byte(8'h80, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_text("//x");
		end_source();
		feed_text("b/*c");
		end_source();
	endtask

	// receiver holds off while bytes closing two tokens keep coming,
	// so the result queue fills and the input side must stall
	task automatic test_backpressure();
		idle_en   = 1'b0;
		hold_left = 300;
		repeat (24) feed_text("a;");
		end_source();
		idle_en = 1'b1;
	endtask

	// well-formed token soup with random content, some noise and comments
	task automatic test_random_source();
		int first;
		int pick;
		int r;
		first = bytes_fed;
		while (bytes_fed - first < RANDOM_BYTES) begin
			if ($urandom_range(0, 59) == 0) idle_en = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				feed_text(kw_words[$urandom_range(0, 22)]);
			end else if (pick < 23) begin
				feed_text("continue");
			end else if (pick < 28) begin
				// keyword with a tail is a plain word unless it spells another keyword
				feed_text(kw_words[$urandom_range(0, 22)]);
				feed_byte(any_word_char(), 1'b0);
			end else if (pick < 40) begin
				r = $urandom_range(0, 52);
				feed_byte(r < 26 ? 8'("a" + r) : r < 52 ? 8'("A" + r - 26) : 8'("_"), 1'b0);
				repeat ($urandom_range(0, 8)) feed_byte(any_word_char(), 1'b0);
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 4)) feed_byte(any_digit(), 1'b0);
				if ($urandom_range(0, 1)) begin
					feed_byte(".", 1'b0);
					repeat ($urandom_range(0, 3)) feed_byte(any_digit(), 1'b0);
				end
				if ($urandom_range(0, 2) == 0) feed_byte($urandom_range(0, 1) ? "f" : "F", 1'b0);
			end else if (pick < 80) begin
				feed_text(op_words[$urandom_range(0, 33)]);
			end else if (pick < 88) begin
				// comment body leans on slashes, stars and line feeds
				r = $urandom_range(0, 1);
				feed_text(r ? "//" : "/*");
				repeat ($urandom_range(0, 8)) begin
					case ($urandom_range(0, 5))
						0:       feed_byte("*", 1'b0);
						1:       feed_byte("/", 1'b0);
						2:       feed_byte(CH_LF, 1'b0);
						default: feed_byte(8'($urandom_range(0, 255)), 1'b0);
					endcase
				end
				if (r) feed_byte(CH_LF, 1'b0);
				else feed_text("*/");
			end else if (pick < 96) begin
				feed_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				end_source();
			end
			// separator, or none so that tokens run into each other
			r = $urandom_range(0, 99);
			if (r < 45) feed_byte(" ", 1'b0);
			else if (r < 52) feed_byte(CH_TAB, 1'b0);
			else if (r < 57) feed_byte(CH_CR, 1'b0);
			else if (r < 67) feed_byte(CH_LF, 1'b0);
		end
		end_source();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatches     = 0;
		tokens_checked = 0;
		bytes_fed      = 0;
		sources_ended  = 0;
		cycle_count    = 0;
		hold_left      = 0;
		idle_en        = 1'b1;
		lex_reset();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_odd_bytes();
		test_backpressure();
		test_random_source();
		s_tvalid <= 1'b0;

		// drain, then keep watching to catch stray tokens
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("fed %0d source bytes in %0d sources, checked %0d tokens", bytes_fed,
			sources_ended, tokens_checked);
		$display("covered keywords, operators, numbers, comments, odd bytes and backpressure");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
